>>> hdl/lssp_pkg.sv
// Shared types, constants and span helper for the large-span sizing policy.
package lssp_pkg;

  localparam int BINS        = 16;
  localparam int SLICE_SHIFT = 16;
  localparam int BIN_W       = (BINS > 1) ? $clog2(BINS) : 1;

  // Field widths fixed by the interface.
  localparam int BIN_IDX_W = 5;
  localparam int BYTES_W   = 21;
  localparam int SLICES_W  = 9;
  localparam int MINB_W    = 5;

  // min_blocks * block_size + overhead + rounding, then >> SLICE_SHIFT.
  localparam int PROD_W = MINB_W + BYTES_W;
  localparam int SUM_W  = 28;
  localparam int NEED_W = SUM_W - SLICE_SHIFT;
  localparam int CMP_W  = (NEED_W > SLICES_W) ? NEED_W : SLICES_W;
  localparam logic [SUM_W-1:0] SLICE_ROUND = SUM_W'((64'd1 << SLICE_SHIFT) - 64'd1);

  localparam logic [2:0] LVL_MAX   = 3'h7;
  localparam logic signed [5:0] PRESS_MIN = -6'sd8;
  localparam logic signed [5:0] PRESS_MAX = 6'sd7;

  typedef enum logic {
    OP_FILL    = 1'b0,
    OP_REQUEST = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    REG_SPAN_ENABLED   = 3'd0,
    REG_GROW_REQUESTS  = 3'd1,
    REG_DECAY_REQUESTS = 3'd2,
    REG_GROW_SHIFT     = 3'd3,
    REG_COMPACT_SLICES = 3'd4,
    REG_FULL_SLICES    = 3'd5,
    REG_MIN_BLOCKS     = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic                span_enabled;
    logic [2:0]          grow_requests;
    logic [3:0]          decay_requests;
    logic [2:0]          grow_shift;
    logic [SLICES_W-1:0] compact_slices;
    logic [SLICES_W-1:0] full_slices;
    logic [MINB_W-1:0]   min_blocks;
  } cfg_t;

  // One table byte: pressure (two's complement) / filled mark / level.
  typedef struct packed {
    logic [3:0] pressure;
    logic       mark;
    logic [2:0] level;
  } bin_entry_t;

  // Level span; sat means it exceeds anything a 9-bit full span can hold.
  typedef struct packed {
    logic                sat;
    logic [SLICES_W-1:0] val;
  } span_t;

  typedef struct packed {
    logic                we;
    bin_entry_t          entry;
    logic                has_result;
    logic [SLICES_W-1:0] span;
  } upd_t;

  function automatic span_t level_span(input logic [SLICES_W-1:0] compact,
                                       input logic [2:0] level,
                                       input logic [2:0] shift);
    logic [5:0]            s;
    logic [2*SLICES_W-1:0] wide;
    span_t                 r;
    s    = 6'(level) * 6'(shift);
    wide = {{SLICES_W{1'b0}}, compact} << s[3:0];
    if (s >= 6'(SLICES_W)) begin
      r.sat = |compact;
      r.val = '0;
    end else begin
      r.sat = |wide[2*SLICES_W-1:SLICES_W];
      r.val = wide[SLICES_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> hdl/lssp_cfg_regs.sv
// Configuration register file of the sizing policy.
module lssp_cfg_regs
  import lssp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  reg_idx_t            wr_index,
  input  logic [SLICES_W-1:0] wr_data,
  output cfg_t                cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        REG_SPAN_ENABLED:   cfg_nxt.span_enabled   = wr_data[0];
        REG_GROW_REQUESTS:  cfg_nxt.grow_requests  = wr_data[2:0];
        REG_DECAY_REQUESTS: cfg_nxt.decay_requests = wr_data[3:0];
        REG_GROW_SHIFT:     cfg_nxt.grow_shift     = wr_data[2:0];
        REG_COMPACT_SLICES: cfg_nxt.compact_slices = wr_data;
        REG_FULL_SLICES:    cfg_nxt.full_slices    = wr_data;
        REG_MIN_BLOCKS:     cfg_nxt.min_blocks     = wr_data[MINB_W-1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.span_enabled   <= 1'b1;
      cfg_r.grow_requests  <= 3'd2;
      cfg_r.decay_requests <= 4'd2;
      cfg_r.grow_shift     <= 3'd1;
      cfg_r.compact_slices <= 9'd16;
      cfg_r.full_slices    <= 9'd64;
      cfg_r.min_blocks     <= 5'd2;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> hdl/lssp_bin_update.sv
// Per-request bin accounting and span computation (combinational).
module lssp_bin_update
  import lssp_pkg::*;
(
  input  cfg_t               cfg,
  input  op_t                op,
  input  logic               in_range,
  input  bin_entry_t         cur,
  input  logic [BYTES_W-1:0] blk_bytes,
  input  logic [BYTES_W-1:0] overhead,
  output upd_t               upd
);

  logic              sized;
  logic signed [5:0] p;
  logic signed [5:0] grow_lim;
  logic signed [5:0] neg_dec;
  logic [2:0]        lvl;
  span_t             cur_span;
  span_t             new_span;
  logic [PROD_W-1:0] prod;
  logic [SUM_W-1:0]  sum;
  logic [NEED_W-1:0] need;
  logic [CMP_W-1:0]  biggest;
  logic [SLICES_W-1:0] slices;

  assign sized = (cfg.compact_slices < cfg.full_slices) && cfg.span_enabled && in_range;
  assign grow_lim = $signed({3'b000, cfg.grow_requests});
  assign neg_dec  = 6'sd0 - $signed({2'b00, cfg.decay_requests});
  assign cur_span = level_span(cfg.compact_slices, cur.level, cfg.grow_shift);

  // pressure / level stepping
  always_comb begin
    p   = $signed({{2{cur.pressure[3]}}, cur.pressure});
    lvl = cur.level;
    if (cur.mark) begin
      p = p + 6'sd1;
      if (p >= grow_lim) begin
        if (lvl != LVL_MAX && !cur_span.sat && cur_span.val < cfg.full_slices) begin
          lvl = lvl + 3'd1;
        end
        p = 6'sd0;
      end
    end else if (lvl != 3'd0) begin
      p = p - 6'sd1;
      if (p <= neg_dec) begin
        lvl = lvl - 3'd1;
        p   = 6'sd0;
      end
    end else if (p > 6'sd0) begin
      p = p - 6'sd1;
    end
    if (p < PRESS_MIN) p = PRESS_MIN;
    if (p > PRESS_MAX) p = PRESS_MAX;
  end

  assign new_span = level_span(cfg.compact_slices, lvl, cfg.grow_shift);

  // bytes needed, rounded up to slices
  assign prod = PROD_W'(cfg.min_blocks) * PROD_W'(blk_bytes);
  assign sum  = SUM_W'(prod) + SUM_W'(overhead) + SLICE_ROUND;
  assign need = sum[SUM_W-1:SLICE_SHIFT];

  always_comb begin
    biggest = (CMP_W'(new_span.val) > CMP_W'(need)) ? CMP_W'(new_span.val) : CMP_W'(need);
    if (new_span.sat || biggest > CMP_W'(cfg.full_slices)) begin
      slices = cfg.full_slices;
    end else begin
      slices = biggest[SLICES_W-1:0];
    end
  end

  always_comb begin
    upd = '0;
    case (op)
      OP_FILL: begin
        upd.we         = in_range;
        upd.entry      = cur;
        upd.entry.mark = 1'b1;
        upd.has_result = 1'b0;
        upd.span       = cfg.full_slices;
      end
      OP_REQUEST: begin
        upd.we             = sized;
        upd.entry.pressure = p[3:0];
        upd.entry.mark     = 1'b0;
        upd.entry.level    = lvl;
        upd.has_result     = 1'b1;
        upd.span           = sized ? slices : cfg.full_slices;
      end
      default: upd = '0;
    endcase
  end

endmodule

>>> hdl/large_span_sizing_policy.sv
// Top level of the large-span sizing policy: input stage, bin table, result stage.
//
// Sizes the page span for large allocation bins from per-bin demand history.
// Each request on the input stream is either a page-filled event (tuser = 0)
// or a page request (tuser = 1) for bin in_tdata[4:0]. Fill events set the
// bin's filled mark and return nothing; every page request returns exactly one
// span, in slices, on the output stream, in request order. Bins at or above
// BINS are treated as non-large: fills are ignored and requests get
// full_slices. Throughput is one request per clock when the output is not
// backpressured: a request is registered at the input, then the bin-table
// read-modify-write and span arithmetic (one 5x21 multiply, two small
// shifters, compares) complete into the output register, which drives
// out_tvalid and out_tdata. The table is a 16-entry flop array, updated
// together with the output register, so back-to-back requests to one bin
// see each other with no bubble.
// Backpressure on the output stalls the input only when both stages are full.
// Configuration writes are taken any cycle out of reset and must only be
// issued while the block is idle; the table is cleared by reset.
module large_span_sizing_policy
  import lssp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // bin_index[4:0], blk_bytes[25:5], overhead[46:26], 0
  input  logic        in_tuser,   // opcode: 0 fill, 1 request
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // span_slices[8:0], 0
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  cfg_t cfg;

  // input stage
  logic                 s1_v_r;
  op_t                  s1_op_r;
  logic [BIN_IDX_W-1:0] s1_bin_r;
  logic [BYTES_W-1:0]   s1_bsize_r;
  logic [BYTES_W-1:0]   s1_ovh_r;

  // bin table
  bin_entry_t tbl_r [BINS];

  // result stage
  logic                out_v_r;
  logic [SLICES_W-1:0] span_r;

  logic       adv;
  logic       in_acc;
  logic       in_range;
  logic [BIN_W-1:0] idx;
  bin_entry_t cur;
  upd_t       upd;

  assign cfg_ready = rst_n;

  lssp_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (reg_idx_t'(cfg_index)),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Input stage moves on whenever the result register is free or draining.
  assign adv       = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = rst_n && (!s1_v_r || adv);
  assign in_acc    = in_tvalid && in_tready;

  assign in_range = 32'(s1_bin_r) < BINS;
  assign idx      = BIN_W'(s1_bin_r);
  assign cur      = in_range ? tbl_r[idx] : '0;

  lssp_bin_update u_upd (
    .cfg        (cfg),
    .op         (s1_op_r),
    .in_range   (in_range),
    .cur        (cur),
    .blk_bytes  (s1_bsize_r),
    .overhead   (s1_ovh_r),
    .upd        (upd)
  );

  // control and table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      for (int i = 0; i < BINS; i++) begin
        tbl_r[i] <= '0;
      end
    end else begin
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (adv) begin
        s1_v_r <= 1'b0;
      end
      if (adv) begin
        out_v_r <= upd.has_result;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
      if (adv && upd.we) begin
        tbl_r[idx] <= upd.entry;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r    <= op_t'(in_tuser);
      s1_bin_r   <= in_tdata[4:0];
      s1_bsize_r <= in_tdata[25:5];
      s1_ovh_r   <= in_tdata[46:26];
    end
    if (adv && upd.has_result) begin
      span_r <= upd.span;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {7'd0, span_r};

endmodule

>>> hdl/lssp_checker.sv
// Port-level checks for the sizing policy, bound to the top level.
module lssp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // upper result bits are padding
  a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[15:9] == 7'd0)
    else $error("result padding not zero");

  // a rise of out_tvalid must follow a page request taken on the input
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready && in_tuser, 2))
    else $error("result without matching request");

  // input only backs off when the output is stalled
  a_in_bp: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output backpressure");

endmodule

bind large_span_sizing_policy lssp_checker u_lssp_checker (.*);
